// File: rtl/nncs_pkg.sv
// Package with the shared types and constants of the nearest-neighbor crop scaler.
`default_nettype none
package nncs_pkg;

   localparam int COMPONENTS = 3;
   localparam int COORD_BITS = 16;

   localparam int PIX_W   = 24;
   localparam int COORD_W = 16;
   localparam int ACC_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PIX_W-1:0]   PIX_MASK   = PIX_W'((64'd1 << (8 * COMPONENTS)) - 64'd1);
   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << COORD_BITS) - 32'd1);
   localparam logic [ACC_W-1:0]   ONE_Q16    = ACC_W'(32'h0001_0000);

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_ORIGIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ORIGIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT   = 3'd6;

   typedef struct packed {
      logic [COORD_W-1:0] source_width;
      logic [ACC_W-1:0]   x_step;
      logic [ACC_W-1:0]   y_step;
      logic [ACC_W-1:0]   col_origin;
      logic [ACC_W-1:0]   row_origin;
      logic [COORD_W-1:0] out_width;
      logic [COORD_W-1:0] out_height;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0]   out_pixel;
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
      logic               frame_done;
   } rsp_word_type;

   // Steps below one source pixel are treated as exactly one.
   function automatic logic [ACC_W-1:0] eff_step(input logic [ACC_W-1:0] s);
      return (s < ONE_Q16) ? ONE_Q16 : s;
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/nncs_req_if.sv
// Handshake interface carrying source pixel words into the scaler.
`default_nettype none
interface nncs_req_if;
   logic                      valid;
   logic                      ready;
   logic [nncs_pkg::PIX_W-1:0] pixel_value;
   logic                      frame_start;

   modport source (output valid, pixel_value, frame_start, input ready);
   modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface
`default_nettype wire

// File: rtl/nncs_rsp_if.sv
// Handshake interface carrying selected pixel words out of the scaler.
`default_nettype none
interface nncs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [nncs_pkg::PIX_W-1:0]   out_pixel;
   logic [nncs_pkg::COORD_W-1:0] out_col;
   logic [nncs_pkg::COORD_W-1:0] out_row;
   logic                        frame_done;

   modport source (output valid, out_pixel, out_col, out_row, frame_done, input ready);
   modport sink   (input valid, out_pixel, out_col, out_row, frame_done, output ready);
endinterface
`default_nettype wire

// File: rtl/nncs_select.sv
// Raster position tracking and nearest-neighbor pixel selection.
`default_nettype none
module nncs_select (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [nncs_pkg::PIX_W-1:0]  pixel_value,
   input  wire logic                        frame_start,
   input  wire nncs_pkg::cfg_type           cfg,
   output      logic                        emit,
   output      nncs_pkg::rsp_word_type      word
);

   logic [nncs_pkg::COORD_W-1:0] src_col_ff, src_col_in;
   logic [nncs_pkg::COORD_W-1:0] src_row_ff, src_row_in;
   logic [nncs_pkg::COORD_W-1:0] out_col_ff, out_col_in;
   logic [nncs_pkg::COORD_W-1:0] out_row_ff, out_row_in;
   logic [nncs_pkg::ACC_W-1:0]   col_acc_ff, col_acc_in;
   logic [nncs_pkg::ACC_W-1:0]   row_acc_ff, row_acc_in;

   logic [nncs_pkg::COORD_W-1:0] cur_src_col, cur_src_row, cur_out_col, cur_out_row;
   logic [nncs_pkg::ACC_W-1:0]   cur_col_acc, cur_row_acc;
   logic [nncs_pkg::COORD_W-1:0] src_col_inc;
   logic                         row_hit;
   logic                         row_wrap;

   // A frame start restarts the scan before this pixel is examined.
   always_comb begin
      cur_src_col = frame_start ? '0 : src_col_ff;
      cur_src_row = frame_start ? '0 : src_row_ff;
      cur_out_col = frame_start ? '0 : out_col_ff;
      cur_out_row = frame_start ? '0 : out_row_ff;
      cur_col_acc = frame_start ? cfg.col_origin : col_acc_ff;
      cur_row_acc = frame_start ? cfg.row_origin : row_acc_ff;
   end

   assign row_hit = (cur_out_row < cfg.out_height) &&
                    (cur_src_row == cur_row_acc[nncs_pkg::ACC_W-1 -: nncs_pkg::COORD_W]);
   assign emit    = row_hit && (cur_out_col < cfg.out_width) &&
                    (cur_src_col == cur_col_acc[nncs_pkg::ACC_W-1 -: nncs_pkg::COORD_W]);

   // A source width of zero wraps after 65536 pixels through the 16-bit increment.
   assign src_col_inc = cur_src_col + nncs_pkg::COORD_W'(1);
   assign row_wrap    = (src_col_inc == cfg.source_width);

   always_comb begin
      word.out_pixel  = pixel_value & nncs_pkg::PIX_MASK;
      word.out_col    = cur_out_col & nncs_pkg::COORD_MASK;
      word.out_row    = cur_out_row & nncs_pkg::COORD_MASK;
      word.frame_done = ({1'b0, cur_out_col} + 17'd1 == {1'b0, cfg.out_width}) &&
                        ({1'b0, cur_out_row} + 17'd1 == {1'b0, cfg.out_height});
   end

   always_comb begin
      src_col_in = src_col_inc;
      src_row_in = cur_src_row;
      out_col_in = emit ? cur_out_col + nncs_pkg::COORD_W'(1) : cur_out_col;
      out_row_in = cur_out_row;
      col_acc_in = emit ? nncs_pkg::sat_add(cur_col_acc, nncs_pkg::eff_step(cfg.x_step))
                        : cur_col_acc;
      row_acc_in = cur_row_acc;
      if (row_wrap) begin
         src_col_in = '0;
         out_col_in = '0;
         col_acc_in = cfg.col_origin;
         if (row_hit) begin
            row_acc_in = nncs_pkg::sat_add(cur_row_acc, nncs_pkg::eff_step(cfg.y_step));
            out_row_in = cur_out_row + nncs_pkg::COORD_W'(1);
         end
         if (cur_src_row != {nncs_pkg::COORD_W{1'b1}}) begin
            src_row_in = cur_src_row + nncs_pkg::COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         col_acc_ff <= '0;
         row_acc_ff <= '0;
      end else if (accept) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         col_acc_ff <= col_acc_in;
         row_acc_ff <= row_acc_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/nearest_neighbor_crop_scaler.sv
// Top level of the nearest-neighbor crop scaler: registers, selection and output staging.
//
// Source pixels enter on req_bus in raster order, one word per accepted
// handshake; frame_start marks the first pixel of a frame and restarts the
// scan. Only the pixels picked by nearest-neighbor sampling with the crop
// origins leave on rsp_bus, each with its output column, row and a
// frame_done mark on the last pixel of the frame.
// One pixel is accepted every cycle while the skid is empty; a selected
// pixel is presented on rsp_bus from the output register. The selection compare
// and the accumulator add sit between the input handshake and the output register.
// When the receiver stalls, a one-word skid register takes the next
// selected pixel, and req_bus.ready drops only once that skid is full, so
// the ready path is registered.
// Configuration is written through csr_we, csr_index and csr_wdata; the user
// must write it only while no frame is in flight, which the block does not
// enforce. Synchronous reset loads the register defaults (unit steps, zero
// origins, 1x1 output), clears the scan counters and empties the output stages.
`default_nettype none
module nearest_neighbor_crop_scaler (
   input  wire logic                               clock,
   input  wire logic                               reset,
   nncs_req_if.sink                                req_bus,
   nncs_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [nncs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [nncs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   nncs_pkg::cfg_type      cfg_ff;
   nncs_pkg::rsp_word_type new_word;
   nncs_pkg::rsp_word_type out_word_ff;
   nncs_pkg::rsp_word_type skid_word_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic                   emit;
   logic                   req_take;
   logic                   rsp_take;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width <= nncs_pkg::COORD_W'(1);
         cfg_ff.x_step       <= nncs_pkg::ONE_Q16;
         cfg_ff.y_step       <= nncs_pkg::ONE_Q16;
         cfg_ff.col_origin   <= '0;
         cfg_ff.row_origin   <= '0;
         cfg_ff.out_width    <= nncs_pkg::COORD_W'(1);
         cfg_ff.out_height   <= nncs_pkg::COORD_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            nncs_pkg::CSR_SOURCE_WIDTH: cfg_ff.source_width <= csr_wdata[nncs_pkg::COORD_W-1:0];
            nncs_pkg::CSR_X_STEP:       cfg_ff.x_step       <= csr_wdata;
            nncs_pkg::CSR_Y_STEP:       cfg_ff.y_step       <= csr_wdata;
            nncs_pkg::CSR_COL_ORIGIN:   cfg_ff.col_origin   <= csr_wdata;
            nncs_pkg::CSR_ROW_ORIGIN:   cfg_ff.row_origin   <= csr_wdata;
            nncs_pkg::CSR_OUT_WIDTH:    cfg_ff.out_width    <= csr_wdata[nncs_pkg::COORD_W-1:0];
            nncs_pkg::CSR_OUT_HEIGHT:   cfg_ff.out_height   <= csr_wdata[nncs_pkg::COORD_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_bus.ready = !skid_valid_ff;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = out_valid_ff && rsp_bus.ready;

   nncs_select u_select (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_take),
      .pixel_value (req_bus.pixel_value),
      .frame_start (req_bus.frame_start),
      .cfg         (cfg_ff),
      .emit        (emit),
      .word        (new_word)
   );

   // Output register plus one skid word.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !rsp_take) begin
         skid_valid_in = req_take && emit;
      end else begin
         out_valid_in = req_take && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_word_ff <= skid_word_ff;
         end
      end else if (out_valid_ff && !rsp_take) begin
         if (req_take && emit) begin
            skid_word_ff <= new_word;
         end
      end else if (req_take && emit) begin
         out_word_ff <= new_word;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_pixel  = out_word_ff.out_pixel;
   assign rsp_bus.out_col    = out_word_ff.out_col;
   assign rsp_bus.out_row    = out_word_ff.out_row;
   assign rsp_bus.frame_done = out_word_ff.frame_done;

   // The skid word is only ever filled behind a waiting output word.
   skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   // A taken output with a full skid must be refilled from the skid.
   skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_take) |=> (out_valid_ff && !skid_valid_ff &&
                                       out_word_ff == $past(skid_word_ff)))
      else $error("skid word not moved into output register");

   // An emitted pixel accepted while the output is stalled lands in the skid.
   stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (req_take && emit && out_valid_ff && !rsp_bus.ready) |=> skid_valid_ff)
      else $error("selected pixel lost during output stall");

endmodule
`default_nettype wire
